// ===== hw/rtl/sob3g_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobel 3x3 gradient package
// Shared widths, register indexes and the word type that travels from the
// front part to the back part through the queue.
// ----------------------------------------------------------------------------
package sob3g_pkg;

    localparam int PIX_W  = 8;
    localparam int GRAD_W = 11;
    localparam int POS_W  = 12;
    localparam int CFG_W  = 13;
    localparam int CFG_IDX_W = 2;

    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;

    localparam logic [CFG_W-1:0] RST_FRAME_WIDTH  = CFG_W'(640);
    localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = CFG_W'(480);

    // Queue between the front and back parts.
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1
    } t_cfg_idx;

    // One classified pixel: the new window column plus what to emit for it.
    typedef struct packed {
        logic [PIX_W-1:0] up;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] px;
        logic             emit;
        logic             last;
        logic [POS_W-1:0] col;
        logic [POS_W-1:0] row;
    } t_item;

endpackage

// ===== hw/rtl/sobel_3x3_gradient_stream.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Streaming 3x3 Sobel gradient
// Takes grayscale pixels in raster order and gives the signed horizontal and
// vertical gradients of every interior pixel, with its position.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                 Payload
//  -------   ---------  ------------------------  ---------------------------
//  config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//  pixel     in         i_valid / o_stall         i_pixel
//  result    out        o_valid / i_stall         o_grad_x, o_grad_y,
//                                                 o_out_col, o_out_row,
//                                                 o_frame_last
//
// One pixel word is taken every cycle while o_stall is low. A result is on the
// outputs once the pixel below-right of its interior pixel has passed the
// line store read stage, the queue and the output register.
// Border pixels produce no result word.
// Reset is synchronous and active low; it sets the frame to 640 by 480,
// clears the raster counters and the window, and empties the pipeline. The
// line stores are not cleared; no interior result reads an unwritten entry.
// A stall on the result side fills the output register, then the two-word
// queue and then the line store read stage; only then does o_stall rise on
// the pixel side.
//
module sobel_3x3_gradient_stream #(
    parameter int MAX_WIDTH  = sob3g_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = sob3g_pkg::DEF_MAX_HEIGHT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [sob3g_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [sob3g_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [sob3g_pkg::PIX_W-1:0]         i_pixel,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [sob3g_pkg::GRAD_W-1:0] o_grad_x,
    output logic signed [sob3g_pkg::GRAD_W-1:0] o_grad_y,
    output logic [sob3g_pkg::POS_W-1:0]         o_out_col,
    output logic [sob3g_pkg::POS_W-1:0]         o_out_row,
    output logic                                o_frame_last
);
    import sob3g_pkg::*;

    logic  push;
    logic  full;
    logic  pop;
    logic  nonempty;
    t_item push_item;
    t_item pop_item;

    // Front part: frame size registers, counters, line stores, classification.
    sob3g_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_pixel     (i_pixel),
        .o_push      (push),
        .o_item      (push_item),
        .i_full      (full)
    );

    // Every pixel word passes the queue, since the window shifts on each one.
    sob3g_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_item     (push_item),
        .o_full     (full),
        .i_pop      (pop),
        .o_nonempty (nonempty),
        .o_item     (pop_item)
    );

    // Back part: window, gradient arithmetic and output register.
    sob3g_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_nonempty   (nonempty),
        .i_item       (pop_item),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_grad_x     (o_grad_x),
        .o_grad_y     (o_grad_y),
        .o_out_col    (o_out_col),
        .o_out_row    (o_out_row),
        .o_frame_last (o_frame_last)
    );

endmodule

// ===== hw/rtl/sob3g_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobel front part
// Holds the frame size registers and the raster counters, reads and updates
// the two line stores, and classifies every accepted pixel.
// ----------------------------------------------------------------------------
module sob3g_front #(
    parameter int MAX_WIDTH  = sob3g_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = sob3g_pkg::DEF_MAX_HEIGHT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [sob3g_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [sob3g_pkg::CFG_W-1:0]       i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [sob3g_pkg::PIX_W-1:0]       i_pixel,
    output logic                              o_push,
    output sob3g_pkg::t_item                  o_item,
    input  logic                              i_full
);
    import sob3g_pkg::*;

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int SWC = $clog2(MAX_WIDTH + 1);
    localparam int SHC = $clog2(MAX_HEIGHT + 1);
    localparam int SW  = (SWC > CFG_W) ? SWC : CFG_W;
    localparam int SH  = (SHC > CFG_W) ? SHC : CFG_W;

    logic [CFG_W-1:0] r_frame_width;
    logic [CFG_W-1:0] r_frame_height;
    logic [CW-1:0]    r_col;
    logic [RW-1:0]    r_row;
    logic [CW-1:0]    n_col;
    logic [RW-1:0]    n_row;

    logic             r_s1_valid;
    logic [CW-1:0]    r_s1_addr;
    logic [PIX_W-1:0] r_s1_px;
    logic             r_s1_emit;
    logic             r_s1_last;
    logic [POS_W-1:0] r_s1_col;
    logic [POS_W-1:0] r_s1_row;
    logic [2*PIX_W-1:0] r_rd;

    logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];

    logic          accept;
    logic          advance;
    logic          cfg_we;
    logic [SW-1:0] cfg_w;
    logic [SH-1:0] cfg_h;
    logic [SW-1:0] w_eff;
    logic [SH-1:0] h_eff;
    logic [SW-1:0] c_ext;
    logic [SW-1:0] c_p1;
    logic [SH-1:0] r_ext;
    logic [SH-1:0] r_p1;
    logic          col_wrap;
    logic          emit;
    logic          last;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= RST_FRAME_WIDTH;
            r_frame_height <= RST_FRAME_HEIGHT;
        end else if (cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sizes below three act as three; above MAX_WIDTH or MAX_HEIGHT, as that limit.
    always_comb begin
        cfg_w = SW'(r_frame_width);
        cfg_h = SH'(r_frame_height);
        if (cfg_w < SW'(3)) begin
            w_eff = SW'(3);
        end else if (cfg_w > SW'(MAX_WIDTH)) begin
            w_eff = SW'(MAX_WIDTH);
        end else begin
            w_eff = cfg_w;
        end
        if (cfg_h < SH'(3)) begin
            h_eff = SH'(3);
        end else if (cfg_h > SH'(MAX_HEIGHT)) begin
            h_eff = SH'(MAX_HEIGHT);
        end else begin
            h_eff = cfg_h;
        end
    end

    assign advance = r_s1_valid && !i_full;
    assign o_stall = r_s1_valid && i_full;
    assign accept  = i_valid && !o_stall;

    assign c_ext    = SW'(r_col);
    assign c_p1     = c_ext + SW'(1);
    assign r_ext    = SH'(r_row);
    assign r_p1     = r_ext + SH'(1);
    assign col_wrap = (c_p1 >= w_eff);
    assign emit     = (c_ext >= SW'(2)) && (c_ext < w_eff)
                   && (r_ext >= SH'(2)) && (r_ext < h_eff);
    assign last     = (c_p1 == w_eff) && (r_p1 == h_eff);

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (accept) begin
            if (col_wrap) begin
                n_col = '0;
                n_row = (r_p1 >= h_eff) ? '0 : RW'(r_p1);
            end else begin
                n_col = CW'(c_p1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (advance) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_addr <= r_col;
            r_s1_px   <= i_pixel;
            r_s1_emit <= emit;
            r_s1_last <= last;
            r_s1_col  <= POS_W'(c_ext - SW'(1));
            r_s1_row  <= POS_W'(r_ext - SH'(1));
        end
    end

    // Line store: upper byte is the row two above, lower byte the row above.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd <= line_mem[r_col];
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            line_mem[r_s1_addr] <= {r_rd[PIX_W-1:0], r_s1_px};
        end
    end

    assign o_push      = advance;
    assign o_item.up   = r_rd[2*PIX_W-1:PIX_W];
    assign o_item.mid  = r_rd[PIX_W-1:0];
    assign o_item.px   = r_s1_px;
    assign o_item.emit = r_s1_emit;
    assign o_item.last = r_s1_last;
    assign o_item.col  = r_s1_col;
    assign o_item.row  = r_s1_row;

`ifndef SYNTHESIS
    a_no_rw_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && advance) |-> (r_col != r_s1_addr))
        else $error("line store read and write hit the same column");

    a_s1_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && i_full) |=> (r_s1_valid && $stable(r_s1_addr) && $stable(r_rd)))
        else $error("stalled front stage lost its word");

    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_s1_valid)
        else $error("accepted pixel did not reach the front stage");
`endif

endmodule

// ===== hw/rtl/sob3g_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobel word queue
// Short queue that decouples the front part from the back part.
// ----------------------------------------------------------------------------
module sob3g_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  sob3g_pkg::t_item  i_item,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_nonempty,
    output sob3g_pkg::t_item  o_item
);
    import sob3g_pkg::*;

    t_item             r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_pop;

    assign o_full     = (r_count == QCNT_W'(QDEPTH));
    assign o_nonempty = (r_count != '0);
    assign do_pop     = i_pop && o_nonempty;
    assign o_item     = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + QPTR_W'(1);
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (do_pop && !i_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !(i_push && !do_pop))
        else $error("word queue overflow");
`endif

endmodule

// ===== hw/rtl/sob3g_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobel back part
// Shifts each queued column into the 3x3 window, computes both gradients
// and holds the result in the output register.
// ----------------------------------------------------------------------------
module sob3g_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_nonempty,
    input  sob3g_pkg::t_item                 i_item,
    output logic                             o_pop,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic signed [sob3g_pkg::GRAD_W-1:0] o_grad_x,
    output logic signed [sob3g_pkg::GRAD_W-1:0] o_grad_y,
    output logic [sob3g_pkg::POS_W-1:0]      o_out_col,
    output logic [sob3g_pkg::POS_W-1:0]      o_out_row,
    output logic                             o_frame_last
);
    import sob3g_pkg::*;

    // Window columns: index 0 top, 1 middle, 2 bottom.
    logic [PIX_W-1:0] r_left  [3];
    logic [PIX_W-1:0] r_cent  [3];
    logic [PIX_W-1:0] right_c [3];

    logic              r_out_valid;
    logic [GRAD_W-1:0] r_gx;
    logic [GRAD_W-1:0] r_gy;
    logic [POS_W-1:0]  r_col;
    logic [POS_W-1:0]  r_row;
    logic              r_last;

    logic [GRAD_W-1:0] sum_right;
    logic [GRAD_W-1:0] sum_left;
    logic [GRAD_W-1:0] sum_bot;
    logic [GRAD_W-1:0] sum_top;
    logic              load;

    assign o_pop = i_nonempty && (!r_out_valid || !i_stall);
    assign load  = o_pop && i_item.emit;

    assign right_c[0] = i_item.up;
    assign right_c[1] = i_item.mid;
    assign right_c[2] = i_item.px;

    // The window after this shift has left = old centre, centre = old right.
    assign sum_right = GRAD_W'(right_c[0]) + (GRAD_W'(right_c[1]) << 1)
                     + GRAD_W'(right_c[2]);
    assign sum_left  = GRAD_W'(r_cent[0]) + (GRAD_W'(r_cent[1]) << 1)
                     + GRAD_W'(r_cent[2]);
    assign sum_bot   = GRAD_W'(r_cent[2]) + (GRAD_W'(r_left[2]) << 1)
                     + GRAD_W'(right_c[2]);
    assign sum_top   = GRAD_W'(r_cent[0]) + (GRAD_W'(r_left[0]) << 1)
                     + GRAD_W'(right_c[0]);

    // r_left holds the column that becomes the centre after the shift.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_left[k] <= '0;
                r_cent[k] <= '0;
            end
        end else if (o_pop) begin
            for (int k = 0; k < 3; k++) begin
                r_cent[k] <= r_left[k];
                r_left[k] <= right_c[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_gx   <= sum_right - sum_left;
            r_gy   <= sum_bot - sum_top;
            r_col  <= i_item.col;
            r_row  <= i_item.row;
            r_last <= i_item.last;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_grad_x     = r_gx;
    assign o_grad_y     = r_gy;
    assign o_out_col    = r_col;
    assign o_out_row    = r_row;
    assign o_frame_last = r_last;

endmodule
